### rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 decoder.
// No dependencies; imported by every module of the decoder.
package u8d_pkg;

    // Byte classes decided by the front part
    typedef enum logic [2:0] {
        CLS_END   = 3'd0,   // zero byte, ends the string
        CLS_ASCII = 3'd1,   // 0xxxxxxx
        CLS_CONT  = 3'd2,   // 10xxxxxx
        CLS_LEAD2 = 3'd3,   // 110xxxxx
        CLS_LEAD3 = 3'd4,   // 1110xxxx
        CLS_LEAD4 = 3'd5    // 1111xxxx, 0xF8-0xFF included
    } u8d_cls_t;

    // One classified byte as it sits in the queue
    typedef struct packed {
        u8d_cls_t   cls;
        logic [6:0] payload;  // byte with its marker bits masked off
    } u8d_item_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } u8d_qstat_t;

    localparam int unsigned CP_W = 22;

    // Continuation counts per sequence form
    localparam logic [1:0] LEN_TWO   = 2'd1;
    localparam logic [1:0] LEN_THREE = 2'd2;
    localparam logic [1:0] LEN_FOUR  = 2'd3;

    // Smallest legal value for each multi-byte form
    localparam logic [CP_W-1:0] MIN_TWO   = 22'h000080;
    localparam logic [CP_W-1:0] MIN_THREE = 22'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR  = 22'h010000;

endpackage

### rtl/utf8_to_code_point_decoder.sv
// UTF-8 decoder top level: front classifier, byte queue and back decoder.
// Depends on u8d_pkg, u8d_front, u8d_queue and u8d_back.

// Decodes a zero-terminated UTF-8 byte stream at one byte per clock while the output
// side does not stall: each accepted byte is classified, queued (two entries) and
// consumed by the back decoder one per cycle, so a byte passes first through the
// queue, written at the transfer edge, and then into the output register.
// A completed
// sequence gives kind 0 with its code point; the zero byte gives kind 1 with
// failed set if the string had a bad leader, bad continuation, overlong form
// or an unfinished sequence. After an error, bytes give no result until the
// zero byte. Stalls on the output side fill the queue and then drop in_ready.
module utf8_to_code_point_decoder
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      data_byte,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            kind,
    output logic [CP_W-1:0] code_point,
    output logic            failed
);

    u8d_qstat_t qstat;
    u8d_item_t  push_item;
    u8d_item_t  head_item;
    logic       push;
    logic       pop;

    u8d_front u_front (
        .data_byte (data_byte),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .qstat     (qstat),
        .push      (push),
        .item      (push_item)
    );

    u8d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .code_point (code_point),
        .failed     (failed)
    );

    // End results carry no code point
    a_end_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> code_point == '0)
        else $error("end result with nonzero code point");

    // Code point results never report failure
    a_cp_not_failed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> !failed)
        else $error("code point result flagged failed");

    // Back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // A transfer into an empty queue leaves it nonempty
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && qstat.empty |=> !qstat.empty)
        else $error("pushed byte lost");

endmodule

### rtl/u8d_front.sv
// Front part: takes input bytes and classifies them for the queue.
// Depends on u8d_pkg.
module u8d_front
    import u8d_pkg::*;
(
    input  logic [7:0] data_byte,
    input  logic       in_valid,
    output logic       in_ready,
    input  u8d_qstat_t qstat,
    output logic       push,
    output u8d_item_t  item
);

    // Accept whenever the queue has room
    assign in_ready = !qstat.full;
    assign push     = in_valid && !qstat.full;

    // Leader / continuation classification
    always_comb
    begin
        if (data_byte == 8'h00)
        begin
            item.cls     = CLS_END;
            item.payload = 7'h00;
        end
        else if (!data_byte[7])
        begin
            item.cls     = CLS_ASCII;
            item.payload = data_byte[6:0];
        end
        else if (!data_byte[6])
        begin
            item.cls     = CLS_CONT;
            item.payload = {1'b0, data_byte[5:0]};
        end
        else if (!data_byte[5])
        begin
            item.cls     = CLS_LEAD2;
            item.payload = {2'b00, data_byte[4:0]};
        end
        else if (!data_byte[4])
        begin
            item.cls     = CLS_LEAD3;
            item.payload = {3'b000, data_byte[3:0]};
        end
        else
        begin
            item.cls     = CLS_LEAD4;
            item.payload = {3'b000, data_byte[3:0]};
        end
    end

endmodule

### rtl/u8d_queue.sv
// Two-entry queue of classified bytes between front and back.
// Depends on u8d_pkg.
module u8d_queue
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  u8d_item_t  push_item,
    input  logic       pop,
    output u8d_item_t  head_item,
    output u8d_qstat_t qstat
);

    u8d_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign head_item   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/u8d_back.sv
// Back part: sequence state, overlong check and the result register.
// Depends on u8d_pkg.
module u8d_back
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  u8d_item_t       head_item,
    input  u8d_qstat_t      qstat,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            kind,
    output logic [CP_W-1:0] code_point,
    output logic            failed
);

    logic [1:0]      pending_reg;
    logic [1:0]      pending_next;
    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] partial_next;
    logic [1:0]      seq_len_reg;
    logic [1:0]      seq_len_next;
    logic            drop_reg;
    logic            drop_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            kind_reg;
    logic            kind_next;
    logic [CP_W-1:0] cp_reg;
    logic [CP_W-1:0] cp_next;
    logic            failed_reg;
    logic            failed_next;

    logic            emit;
    logic [CP_W-1:0] shifted;
    logic [CP_W-1:0] floor_val;

    // Take the head byte whenever the result slot is free or draining
    assign pop = !qstat.empty && (!out_valid_reg || out_ready);

    assign shifted = {partial_reg[CP_W-7:0], head_item.payload[5:0]};

    always_comb
    begin
        unique case (seq_len_reg)
            LEN_TWO:   floor_val = MIN_TWO;
            LEN_THREE: floor_val = MIN_THREE;
            default:   floor_val = MIN_FOUR;
        endcase
    end

    // Decode step for the head byte
    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        seq_len_next = seq_len_reg;
        drop_next    = drop_reg;
        emit         = 1'b0;
        kind_next    = 1'b0;
        cp_next      = '0;
        failed_next  = 1'b0;

        if (head_item.cls == CLS_END)
        begin
            emit         = 1'b1;
            kind_next    = 1'b1;
            failed_next  = drop_reg || (pending_reg != 2'd0);
            pending_next = 2'd0;
            partial_next = '0;
            seq_len_next = 2'd0;
            drop_next    = 1'b0;
        end
        else if (drop_reg)
        begin
            // discard until the zero byte
        end
        else if (pending_reg != 2'd0)
        begin
            if (head_item.cls != CLS_CONT)
            begin
                drop_next    = 1'b1;
                pending_next = 2'd0;
            end
            else
            begin
                partial_next = shifted;
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1)
                begin
                    if (shifted < floor_val)
                        drop_next = 1'b1;
                    else
                    begin
                        emit    = 1'b1;
                        cp_next = shifted;
                    end
                end
            end
        end
        else
        begin
            unique case (head_item.cls)
                CLS_ASCII:
                begin
                    emit    = 1'b1;
                    cp_next = {{(CP_W-7){1'b0}}, head_item.payload};
                end
                CLS_LEAD2:
                begin
                    partial_next = {{(CP_W-7){1'b0}}, head_item.payload};
                    seq_len_next = LEN_TWO;
                    pending_next = LEN_TWO;
                end
                CLS_LEAD3:
                begin
                    partial_next = {{(CP_W-7){1'b0}}, head_item.payload};
                    seq_len_next = LEN_THREE;
                    pending_next = LEN_THREE;
                end
                CLS_LEAD4:
                begin
                    partial_next = {{(CP_W-7){1'b0}}, head_item.payload};
                    seq_len_next = LEN_FOUR;
                    pending_next = LEN_FOUR;
                end
                default:
                begin
                    // stray continuation where a leader belongs
                    drop_next = 1'b1;
                end
            endcase
        end
    end

    // Result slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (pop && emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            partial_reg   <= '0;
            seq_len_reg   <= 2'd0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                seq_len_reg <= seq_len_next;
                drop_reg    <= drop_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg   <= kind_next;
            cp_reg     <= cp_next;
            failed_reg <= failed_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign code_point = cp_reg;
    assign failed     = failed_reg;

endmodule

### dv/u8d_decode_checker.sv
// Checker for the UTF-8 decoder: watches both channels, predicts each result and compares.
// Depends on u8d_pkg for the code point width and the sequence length and minimum constants.
`timescale 1ns / 100ps

module u8d_decode_checker
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      data_byte,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  logic            kind,
    input  logic [CP_W-1:0] code_point,
    input  logic            failed,
    output int              mismatch_count,
    output int              pending_results
);

    localparam logic KIND_CODE   = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [CP_W-1:0] code_point;
        logic            failed;
    } decoded_t;

    decoded_t        expected_q[$];

    // Predictor state
    logic [1:0]      conts_left;
    logic [CP_W-1:0] value_acc;
    logic [1:0]      form_len;
    logic            in_error;

    task automatic clear_decoder();
        conts_left = 2'd0;
        value_acc  = '0;
        form_len   = 2'd0;
        in_error   = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
    endtask

    // Advance the decoder by one byte, queue the result it gives, if any
    task automatic decode_byte(input logic [7:0] b);
        decoded_t        res;
        logic [CP_W-1:0] floor_v;
        res = '0;
        if (b == 8'h00)
        begin
            // zero byte always closes the string
            res.kind   = KIND_END;
            res.failed = in_error || (conts_left != 2'd0);
            expected_q.push_back(res);
            clear_decoder();
        end
        else if (!in_error)
        begin
            if (conts_left != 2'd0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    // bad continuation: swallow and drop to the zero byte
                    in_error   = 1'b1;
                    conts_left = 2'd0;
                end
                else
                begin
                    value_acc  = {value_acc[CP_W-7:0], b[5:0]};
                    conts_left = conts_left - 2'd1;
                    if (conts_left == 2'd0)
                    begin
                        case (form_len)
                            LEN_TWO:   floor_v = MIN_TWO;
                            LEN_THREE: floor_v = MIN_THREE;
                            default:   floor_v = MIN_FOUR;
                        endcase
                        if (value_acc < floor_v)
                            in_error = 1'b1;    // overlong form
                        else
                        begin
                            res.kind       = KIND_CODE;
                            res.code_point = value_acc;
                            expected_q.push_back(res);
                        end
                    end
                end
            end
            else if (!b[7])
            begin
                res.kind       = KIND_CODE;
                res.code_point = {{(CP_W-7){1'b0}}, b[6:0]};
                expected_q.push_back(res);
            end
            else if (!b[6])
                in_error = 1'b1;                // stray continuation as leader
            else
            begin
                if (!b[5])
                begin
                    value_acc = {{(CP_W-5){1'b0}}, b[4:0]};
                    form_len  = LEN_TWO;
                end
                else if (!b[4])
                begin
                    value_acc = {{(CP_W-4){1'b0}}, b[3:0]};
                    form_len  = LEN_THREE;
                end
                else
                begin
                    // 0xF0-0xFF, low nibble is payload
                    value_acc = {{(CP_W-4){1'b0}}, b[3:0]};
                    form_len  = LEN_FOUR;
                end
                conts_left = form_len;
            end
        end
    endtask

    // Results are checked before the same edge's input is predicted
    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            clear_decoder();
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with none expected",
                                    32'({kind, code_point, failed}), 32'd0);
                else
                begin
                    want = expected_q.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", 32'(kind), 32'(want.kind));
                    if (code_point !== want.code_point)
                        report_mismatch("code_point", 32'(code_point),
                                        32'(want.code_point));
                    if (failed !== want.failed)
                        report_mismatch("failed", 32'(failed), 32'(want.failed));
                end
            end
            if (in_valid && in_ready)
                decode_byte(data_byte);
            pending_results <= expected_q.size();
        end
    end

endmodule

### dv/tb_top.sv
// Testbench top for utf8_to_code_point_decoder: clock, reset, byte stimulus and verdict.
// Depends on u8d_pkg, the decoder RTL and u8d_decode_checker.
`timescale 1ns / 100ps

module tb_top
    import u8d_pkg::*;
();

    localparam int RESET_CYCLES = 7;
    localparam int TARGET_BYTES = 1350;
    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;

    typedef enum int {
        STR_CLEAN,
        STR_NOISE,
        STR_CUT,
        STR_CORRUPT
    } str_kind_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic [7:0]      data_byte = 8'h00;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic            kind;
    logic [CP_W-1:0] code_point;
    logic            failed;

    int              mismatch_count;
    int              pending_results;
    bit              gaps_on      = 1'b1;
    int              quiet_cycles = 0;
    int              sent_bytes   = 0;
    logic [7:0]      str_q[$];

    // Boundary values, 0xF8-0xFF leader, then each error form in a string of its own
    logic [7:0] directed_q[$] = '{
        8'h7f, 8'hc2, 8'h80, 8'hf0, 8'h90, 8'h80, 8'h80,
        8'hff, 8'hbf, 8'hbf, 8'hbf, 8'h00,
        8'hc1, 8'hbf, 8'h00,                // two-byte overlong
        8'he0, 8'h9f, 8'hbf, 8'h00,         // three-byte overlong
        8'hf0, 8'h8f, 8'hbf, 8'hbf, 8'h00,  // four-byte overlong
        8'h80, 8'h41, 8'h00,                // bad leader, then dropped byte
        8'hc2, 8'h41, 8'h00,                // bad continuation
        8'he2, 8'h82, 8'h00                 // zero inside a sequence
    };

    always
    begin
        #5 clk = ~clk;
    end

    utf8_to_code_point_decoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .code_point (code_point),
        .failed     (failed)
    );

    u8d_decode_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_byte       (data_byte),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .code_point      (code_point),
        .failed          (failed),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Mostly short idles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // One byte transfer; returns at the edge where it is accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_bytes++;
    endtask

    // Encode one character of the given byte count, optionally in overlong form
    task automatic append_char(input int nbytes, input bit overlong);
        logic [21:0] v;
        case (nbytes)
            1:       v = 22'($urandom_range(1, 'h7f));
            2:       v = overlong ? 22'($urandom_range(0, 'h7f))
                                  : 22'($urandom_range('h80, 'h7ff));
            3:       v = overlong ? 22'($urandom_range(0, 'h7ff))
                                  : 22'($urandom_range('h800, 'hffff));
            default: v = overlong ? 22'($urandom_range(0, 'hffff))
                                  : 22'($urandom_range('h10000, 'h3fffff));
        endcase
        case (nbytes)
            1:
                str_q.push_back({1'b0, v[6:0]});
            2:
            begin
                str_q.push_back({3'b110, v[10:6]});
                str_q.push_back({2'b10, v[5:0]});
            end
            3:
            begin
                str_q.push_back({4'b1110, v[15:12]});
                str_q.push_back({2'b10, v[11:6]});
                str_q.push_back({2'b10, v[5:0]});
            end
            default:
            begin
                // top payload bits land in the leader's low nibble, 0xF8-0xFF included
                str_q.push_back({4'b1111, v[21:18]});
                str_q.push_back({2'b10, v[17:12]});
                str_q.push_back({2'b10, v[11:6]});
                str_q.push_back({2'b10, v[5:0]});
            end
        endcase
    endtask

    // Mostly well-formed strings; some noise, truncated and corrupted ones
    task automatic build_string();
        str_kind_t sk;
        int        r;
        int        pos;
        str_q.delete();
        r = $urandom_range(0, 9);
        if (r < 7)
            sk = STR_CLEAN;
        else if (r == 7)
            sk = STR_NOISE;
        else if (r == 8)
            sk = STR_CUT;
        else
            sk = STR_CORRUPT;
        if (sk == STR_NOISE)
            repeat ($urandom_range(1, 10))
                str_q.push_back(8'($urandom_range(1, 255)));
        else
        begin
            repeat ($urandom_range(0, 8))
                append_char($urandom_range(1, 4), $urandom_range(0, 9) == 0);
            if (sk == STR_CUT)
            begin
                // drop the final continuation so the zero byte lands mid-sequence
                append_char($urandom_range(2, 4), 1'b0);
                void'(str_q.pop_back());
            end
            else if (sk == STR_CORRUPT && str_q.size() != 0)
            begin
                pos        = $urandom_range(0, str_q.size() - 1);
                str_q[pos] = 8'($urandom_range(1, 255));
            end
        end
        str_q.push_back(8'h00);
    endtask

    // Output side: ready runs broken by stalls while gaps are enabled
    initial
    begin
        int stall_len;
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall_len = gaps_on ? idle_len() : 0;
            if (stall_len > 0)
            begin
                out_ready <= 1'b0;
                do
                begin
                    @(posedge clk);
                    stall_len--;
                end
                while (stall_len > 0 && gaps_on);
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and verdict
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_q[i])
            send_byte(directed_q[i]);

        while (sent_bytes < TARGET_BYTES)
        begin
            build_string();
            gaps_on = ($urandom_range(0, 4) != 0);
            foreach (str_q[i])
                send_byte(str_q[i]);
        end

        in_valid <= 1'b0;
        gaps_on = 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
